FILE: src/ulq_pkg.sv
// ----------------------------------------------------------------------------
// ulq_pkg
// Shared constants and types of the uniform level quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ulq_pkg;

   localparam int ULQ_MAX_LEVELS   = 256;
   localparam int ULQ_SAMPLE_WIDTH = 16;

   localparam int ULQ_LOW_RESET    = -4096;
   localparam int ULQ_HIGH_RESET   = 4096;
   localparam int ULQ_COUNT_RESET  = 256;
   localparam int ULQ_COUNT_WIDTH  = 9;
   localparam int ULQ_INDEX_WIDTH  = 8;

   localparam logic [1:0] REG_LOW_BOUND   = 2'd0;
   localparam logic [1:0] REG_HIGH_BOUND  = 2'd1;
   localparam logic [1:0] REG_LEVEL_COUNT = 2'd2;

   typedef struct packed {
      logic empty;
      logic over;
   } ulq_flag_type;

endpackage

`default_nettype wire

FILE: src/uniform_level_quantizer_unit.sv
// ----------------------------------------------------------------------------
// uniform_level_quantizer_unit
// Snaps each signed sample to the nearest of level_count evenly spaced
// levels between low_bound and high_bound; ties go to the upper level.
//
// Channels: req_* carries one sample per transfer; rsp_* returns the
// quantized value, its level index and a clip flag. csr_* writes the
// three registers (0 low_bound, 1 high_bound, 2 level_count) and is
// always ready; write it only while no sample is in flight.
// The pipeline depth is set by bit-per-stage dividers in series: one finds
// the first level at or above the sample, then a parallel pair computes
// the two level values around it.
// Throughput: one sample per cycle while the pipeline is not stalled.
// Reset clears all valid bits and restores the register defaults.
// When rsp_tready is low with a result waiting, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module uniform_level_quantizer_unit
   import ulq_pkg::*;
#(
   parameter int MAX_LEVELS   = ULQ_MAX_LEVELS,
   parameter int SAMPLE_WIDTH = ULQ_SAMPLE_WIDTH,
   localparam int SW  = SAMPLE_WIDTH,
   localparam int CW  = (SW > ULQ_COUNT_WIDTH) ? SW : ULQ_COUNT_WIDTH,
   localparam int RQW = ((SW + 7) / 8) * 8,
   localparam int RSW = ((SW + ULQ_INDEX_WIDTH + 1 + 7) / 8) * 8
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [RQW-1:0] req_tdata,   // sample
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [RSW-1:0]      rsp_tdata,   // quantized, level_index, clipped
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [1:0]     csr_index,
   input  wire logic [CW-1:0]  csr_wdata
);

   localparam int IW  = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;
   localparam int NCW = (IW + 1 > ULQ_COUNT_WIDTH) ? IW + 1 : ULQ_COUNT_WIDTH;
   localparam int TW  = SW + IW + 2;
   localparam int PW  = SW + 1 + IW;

   logic signed [SW-1:0]  low_ff, high_ff;
   logic [ULQ_COUNT_WIDTH-1:0] count_ff;

   logic                  ce;
   logic [NCW-1:0]        n_ext, n_clamp;
   logic [IW-1:0]         m;
   logic [SW:0]           span;

   logic signed [SW-1:0]  s_in;
   ulq_flag_type          flag_in;
   logic [SW:0]           d_in;

   logic                  a_vld_ff;
   logic signed [SW-1:0]  a_smp_ff;
   ulq_flag_type          a_flag_ff;
   logic [SW:0]           a_d_ff;

   logic                  b_vld_ff;
   logic [PW-1:0]         b_prod_ff;
   logic [TW-1:0]         b_tag_ff;

   logic                  d1_vld;
   logic [IW-1:0]         d1_quo;
   logic [SW:0]           d1_rem;
   logic [TW-1:0]         d1_tag;

   logic                  c_vld_ff;
   logic [IW-1:0]         c_i_ff;
   logic [TW-1:0]         c_tag_ff;
   logic [IW-1:0]         i_in;

   logic                  d_vld_ff;
   logic [PW-1:0]         d_pu_ff, d_pd_ff;
   logic [TW-1:0]         d_tag_ff;

   logic                  d2_vld;
   logic [SW:0]           d2_quo, d3_quo;
   logic [TW-1:0]         d2_tag;

   logic signed [SW-1:0]  e_smp;
   logic [IW-1:0]         e_i;
   ulq_flag_type          e_flag;
   logic signed [SW+1:0]  lo_x, s_x, up_x, dn_x;
   logic [SW-1:0]         q_in;
   logic [IW-1:0]         idx_in;
   logic                  clip_in;

   logic                  rsp_vld_ff;
   logic [SW-1:0]         rsp_q_ff;
   logic [ULQ_INDEX_WIDTH-1:0] rsp_idx_ff;
   logic                  rsp_clip_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= SW'(ULQ_LOW_RESET);
         high_ff  <= SW'(ULQ_HIGH_RESET);
         count_ff <= ULQ_COUNT_WIDTH'(ULQ_COUNT_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            REG_LOW_BOUND:   low_ff   <= csr_wdata[SW-1:0];
            REG_HIGH_BOUND:  high_ff  <= csr_wdata[SW-1:0];
            REG_LEVEL_COUNT: count_ff <= csr_wdata[ULQ_COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign n_ext   = NCW'(count_ff);
   assign n_clamp = (n_ext < NCW'(2)) ? NCW'(2) :
                    (n_ext > NCW'(MAX_LEVELS)) ? NCW'(MAX_LEVELS) : n_ext;
   assign m       = IW'(n_clamp - NCW'(1));
   assign span    = (SW+1)'({high_ff[SW-1], high_ff} - {low_ff[SW-1], low_ff});

   assign ce         = !rsp_vld_ff || rsp_tready;
   assign req_tready = ce;

   // stage A: range checks
   assign s_in          = req_tdata[SW-1:0];
   assign flag_in.empty = high_ff <= low_ff;
   assign flag_in.over  = s_in > high_ff;
   assign d_in = (flag_in.empty || flag_in.over || s_in < low_ff) ? '0 :
                 (SW+1)'({s_in[SW-1], s_in} - {low_ff[SW-1], low_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (ce) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= d1_vld;
         d_vld_ff <= c_vld_ff;
         rsp_vld_ff <= d2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_smp_ff  <= s_in;
         a_flag_ff <= flag_in;
         a_d_ff    <= d_in;
      end
   end

   // stage B: scale offset by level spacing count
   always_ff @(posedge clock) begin
      if (ce) begin
         b_prod_ff <= PW'(a_d_ff) * PW'(m);
         b_tag_ff  <= {a_flag_ff, IW'(0), a_smp_ff};
      end
   end

   ulq_div #(.NW(PW), .DW(SW + 1), .QW(IW), .TW(TW)) u_div_index (
      .clock (clock),
      .reset (reset),
      .ce    (ce),
      .vld_i (b_vld_ff),
      .num_i (b_prod_ff),
      .den_i (b_tag_ff[TW-1] ? (SW+1)'(1) : span),
      .tag_i (b_tag_ff),
      .vld_o (d1_vld),
      .quo_o (d1_quo),
      .rem_o (d1_rem),
      .tag_o (d1_tag)
   );

   // stage C: first level at or above the sample
   assign i_in = (d1_quo == '0) ? IW'(1) : IW'(d1_quo + IW'(d1_rem != '0));

   always_ff @(posedge clock) begin
      if (ce) begin
         c_i_ff   <= i_in;
         c_tag_ff <= d1_tag;
      end
   end

   // stage D: scaled level offsets
   always_ff @(posedge clock) begin
      if (ce) begin
         d_pu_ff  <= PW'(c_i_ff) * PW'(span);
         d_pd_ff  <= PW'(c_i_ff - IW'(1)) * PW'(span);
         d_tag_ff <= {c_tag_ff[TW-1 -: 2], c_i_ff, c_tag_ff[SW-1:0]};
      end
   end

   ulq_div #(.NW(PW), .DW(IW), .QW(SW + 1), .TW(TW)) u_div_upper (
      .clock (clock),
      .reset (reset),
      .ce    (ce),
      .vld_i (d_vld_ff),
      .num_i (d_pu_ff),
      .den_i (m),
      .tag_i (d_tag_ff),
      .vld_o (d2_vld),
      .quo_o (d2_quo),
      .rem_o (),
      .tag_o (d2_tag)
   );

   ulq_div #(.NW(PW), .DW(IW), .QW(SW + 1), .TW(1)) u_div_lower (
      .clock (clock),
      .reset (reset),
      .ce    (ce),
      .vld_i (d_vld_ff),
      .num_i (d_pd_ff),
      .den_i (m),
      .tag_i (1'b0),
      .vld_o (),
      .quo_o (d3_quo),
      .rem_o (),
      .tag_o ()
   );

   // stage E: pick the nearer level
   assign e_smp  = d2_tag[SW-1:0];
   assign e_i    = d2_tag[SW +: IW];
   assign e_flag = d2_tag[TW-1 -: 2];
   assign lo_x   = {{2{low_ff[SW-1]}}, low_ff};
   assign s_x    = {{2{e_smp[SW-1]}}, e_smp};
   assign up_x   = lo_x + $signed({1'b0, d2_quo});
   assign dn_x   = lo_x + $signed({1'b0, d3_quo});

   always_comb begin
      if (e_flag.empty) begin
         q_in    = low_ff;
         idx_in  = '0;
         clip_in = e_smp != low_ff;
      end else if (e_flag.over) begin
         q_in    = high_ff;
         idx_in  = m;
         clip_in = 1'b1;
      end else begin
         clip_in = e_smp < low_ff;
         if ((s_x - dn_x) < (up_x - s_x)) begin
            q_in   = dn_x[SW-1:0];
            idx_in = e_i - IW'(1);
         end else begin
            q_in   = up_x[SW-1:0];
            idx_in = e_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_q_ff    <= q_in;
         rsp_idx_ff  <= ULQ_INDEX_WIDTH'(idx_in);
         rsp_clip_ff <= clip_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSW'({rsp_clip_ff, rsp_idx_ff, rsp_q_ff});

endmodule

`default_nettype wire

FILE: src/ulq_div.sv
// ----------------------------------------------------------------------------
// ulq_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ulq_div
   import ulq_pkg::*;
#(
   parameter int NW = 25,
   parameter int DW = 17,
   parameter int QW = 8,
   parameter int TW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          ce,
   input  wire logic          vld_i,
   input  wire logic [NW-1:0] num_i,
   input  wire logic [DW-1:0] den_i,
   input  wire logic [TW-1:0] tag_i,
   output logic               vld_o,
   output logic [QW-1:0]      quo_o,
   output logic [DW-1:0]      rem_o,
   output logic [TW-1:0]      tag_o
);

   logic          vld_ff [QW];
   logic [NW-1:0] num_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [TW-1:0] tag_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          vld_in;
      logic [NW-1:0] num_in;
      logic [DW-1:0] den_in;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;
      logic [TW-1:0] tag_in;
      logic [DW:0]   trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign vld_in = vld_i;
         assign num_in = num_i;
         assign den_in = den_i;
         assign rem_in = DW'(num_i >> QW);
         assign quo_in = '0;
         assign tag_in = tag_i;
      end else begin : g_next
         assign vld_in = vld_ff[k-1];
         assign num_in = num_ff[k-1];
         assign den_in = den_ff[k-1];
         assign rem_in = rem_ff[k-1];
         assign quo_in = quo_ff[k-1];
         assign tag_in = tag_ff[k-1];
      end

      assign trial = {rem_in, num_in[QW-1-k]};
      assign ge    = trial >= {1'b0, den_in};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ce) begin
            vld_ff[k] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            num_ff[k] <= num_in;
            den_ff[k] <= den_in;
            rem_ff[k] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
            quo_ff[k] <= QW'({quo_in, ge});
            tag_ff[k] <= tag_in;
         end
      end
   end

   assign vld_o = vld_ff[QW-1];
   assign quo_o = quo_ff[QW-1];
   assign rem_o = rem_ff[QW-1];
   assign tag_o = tag_ff[QW-1];

endmodule

`default_nettype wire
